FILE: rtl/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the RGB 3x3 ring-mean filter
// Pixel and window-column types, image limits, register indexes and the
// dimension clamp used when a size register is written.
// ----------------------------------------------------------------------------
package rmf_pkg;

   // Image limits and derived widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int DIM_W      = 11;                    // width of a size register
   localparam int COL_W      = $clog2(MAX_WIDTH);     // column counter / line address
   localparam int ROW_W      = $clog2(MAX_HEIGHT);    // row counter
   localparam int POS_W      = 10;                    // out_row / out_col field width
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int SUM_W      = CHAN_W + 3;            // eight channel values
   localparam int IDX_W      = 1;                     // register index width

   // Register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_idx_type;

   // One pixel, red in the lowest bits as on the stream
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pix_type;

   // One window column: top is two rows up, bot is the current row
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } col_type;

   // Clamp a written size to 3 .. hi
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] res;
      if (v < DIM_W'(3)) begin
         res = DIM_W'(3);
      end else if (v > hi) begin
         res = hi;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

FILE: rtl/rmf_ram.sv
// ----------------------------------------------------------------------------
// rmf_ram: generic single-write, single-read RAM
// Registered read with an enable; a read and a write to the same address in
// one cycle return the old contents.
// ----------------------------------------------------------------------------
module rmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first storage
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rmf_cell.sv
// ----------------------------------------------------------------------------
// rmf_cell: one column cell of the 3x3 window
// Holds three vertically adjacent pixels and hands them to the next cell
// each time a pixel beat moves through the window.
// ----------------------------------------------------------------------------
module rmf_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  rmf_pkg::col_type col_in,
   output rmf_pkg::col_type col_out
);

   rmf_pkg::col_type col_ff;

   // Column register, no reset: contents are valid once a frame has filled it
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

FILE: rtl/rmf_mean.sv
// ----------------------------------------------------------------------------
// rmf_mean: rounded ring mean of a 3x3 window
// Per channel, sums the eight neighbours (centre left out) and returns
// (sum + 4) >> 3.
// ----------------------------------------------------------------------------
module rmf_mean (
   input  rmf_pkg::col_type col_0,   // oldest column
   input  rmf_pkg::col_type col_1,   // centre column
   input  rmf_pkg::col_type col_2,   // newest column
   output rmf_pkg::pix_type mean
);

   // Eight-operand add plus rounding for one channel
   function automatic logic [rmf_pkg::CHAN_W-1:0] ring8(
      input logic [rmf_pkg::CHAN_W-1:0] a0, input logic [rmf_pkg::CHAN_W-1:0] a1,
      input logic [rmf_pkg::CHAN_W-1:0] a2, input logic [rmf_pkg::CHAN_W-1:0] a3,
      input logic [rmf_pkg::CHAN_W-1:0] a4, input logic [rmf_pkg::CHAN_W-1:0] a5,
      input logic [rmf_pkg::CHAN_W-1:0] a6, input logic [rmf_pkg::CHAN_W-1:0] a7);
      logic [rmf_pkg::SUM_W-1:0] s01, s23, s45, s67, sum;
      s01 = rmf_pkg::SUM_W'(a0) + rmf_pkg::SUM_W'(a1);
      s23 = rmf_pkg::SUM_W'(a2) + rmf_pkg::SUM_W'(a3);
      s45 = rmf_pkg::SUM_W'(a4) + rmf_pkg::SUM_W'(a5);
      s67 = rmf_pkg::SUM_W'(a6) + rmf_pkg::SUM_W'(a7);
      sum = s01 + s23 + s45 + s67 + rmf_pkg::SUM_W'(4);
      return sum[rmf_pkg::SUM_W-1:3];
   endfunction

   // Red, green and blue in parallel
   always_comb begin
      mean.red   = ring8(col_0.top.red,   col_0.mid.red,   col_0.bot.red,
                         col_1.top.red,   col_1.bot.red,
                         col_2.top.red,   col_2.mid.red,   col_2.bot.red);
      mean.green = ring8(col_0.top.green, col_0.mid.green, col_0.bot.green,
                         col_1.top.green, col_1.bot.green,
                         col_2.top.green, col_2.mid.green, col_2.bot.green);
      mean.blue  = ring8(col_0.top.blue,  col_0.mid.blue,  col_0.bot.blue,
                         col_1.top.blue,  col_1.bot.blue,
                         col_2.top.blue,  col_2.mid.blue,  col_2.bot.blue);
   end

endmodule

FILE: rtl/rgb_ring_mean_filter_3x3.sv
// ----------------------------------------------------------------------------
// rgb_ring_mean_filter_3x3: streaming 3x3 ring-mean filter for RGB pixels
// Two line-store RAMs feed a chain of three window column cells; each
// interior pixel gets the rounded mean of its eight neighbours.
//
//   channel  | direction | beat contents
//   ---------+-----------+-------------------------------------------------
//   req_     | in        | one raster pixel (red, green, blue)
//   rsp_     | out       | filtered interior pixel, row, column, last flag
//   csr_     | in        | write of image_width (0) or image_height (1)
//
// One pixel beat per clock while the skid entry is empty. A result reaches
// the output register from the beat of the pixel diagonally below-right of
// it (line-store read, window shift, adder tree into the output register).
// Reset restores the 1024 x 1024 size and clears counters and valid flags
// only. A stalled result waits in the output register with one skid entry
// behind it; req_tready drops only while the skid entry is full.
// ----------------------------------------------------------------------------
module rgb_ring_mean_filter_3x3 (
   input  logic                       clock,
   input  logic                       reset,
   // pixel input stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,   // red_in, green_in, blue_in
   // result stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [47:0]                rsp_tdata,   // red_out, green_out, blue_out,
                                                   // out_row, out_col, zero pad
   output logic                       rsp_tlast,   // frame_last
   // configuration writes
   input  logic                       csr_wen,
   input  logic [rmf_pkg::IDX_W-1:0]  csr_index,
   input  logic [rmf_pkg::DIM_W-1:0]  csr_wdata
);

   localparam int DW = rmf_pkg::DIM_W;
   localparam int CW = rmf_pkg::COL_W;
   localparam int RW = rmf_pkg::ROW_W;
   localparam int PW = rmf_pkg::POS_W;

   // Result beat contents
   typedef struct packed {
      logic [PW-1:0]    col;
      logic [PW-1:0]    row;
      rmf_pkg::pix_type pix;
   } res_type;

   // Per-beat information carried down the pipe
   typedef struct packed {
      logic          emit;
      logic          last;
      logic [PW-1:0] row;
      logic [PW-1:0] col;
   } meta_type;

   // ------------------------------------------------------------------
   // Size registers (kept clamped) and raster position
   // ------------------------------------------------------------------
   logic [DW-1:0] width_ff, width_in;
   logic [DW-1:0] height_ff, height_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic          skid_full_ff, skid_full_in;
   logic          pipe_en;
   logic          accept;
   logic          end_of_row;
   meta_type      meta0;

   assign pipe_en    = !skid_full_ff;
   assign req_tready = pipe_en;
   assign accept     = req_tvalid && pipe_en;

   assign end_of_row = (DW'(col_ff) + DW'(1)) == width_ff;

   always_comb begin
      meta0.emit = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
      meta0.last = ((DW'(row_ff) + DW'(1)) == height_ff) && end_of_row;
      meta0.row  = PW'(row_ff - RW'(1));
      meta0.col  = PW'(col_ff - CW'(1));
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_wen) begin
         unique case (rmf_pkg::reg_idx_type'(csr_index))
            rmf_pkg::REG_IMAGE_WIDTH: begin
               width_in = rmf_pkg::clamp_dim(csr_wdata, DW'(rmf_pkg::MAX_WIDTH));
            end
            rmf_pkg::REG_IMAGE_HEIGHT: begin
               height_in = rmf_pkg::clamp_dim(csr_wdata, DW'(rmf_pkg::MAX_HEIGHT));
            end
            default: begin
            end
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (end_of_row) begin
            col_in = '0;
            if ((DW'(row_ff) + DW'(1)) == height_ff) begin
               row_in = '0;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DW'(rmf_pkg::MAX_WIDTH);
         height_ff <= DW'(rmf_pkg::MAX_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Line stores: bank (row & 1) holds the older row and is overwritten
   // ------------------------------------------------------------------
   logic [rmf_pkg::PIX_W-1:0] bank0_rd, bank1_rd;
   logic                      par0;

   assign par0 = row_ff[0];

   rmf_ram #(.WIDTH(rmf_pkg::PIX_W), .DEPTH(rmf_pkg::MAX_WIDTH)) u_bank0 (
      .clock   (clock),
      .wr_en   (accept && !par0),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (bank0_rd)
   );

   rmf_ram #(.WIDTH(rmf_pkg::PIX_W), .DEPTH(rmf_pkg::MAX_WIDTH)) u_bank1 (
      .clock   (clock),
      .wr_en   (accept && par0),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (bank1_rd)
   );

   // ------------------------------------------------------------------
   // Stage 1: line-store data arrives next to the incoming pixel
   // ------------------------------------------------------------------
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_par_ff;
   rmf_pkg::pix_type s1_pix_ff;
   meta_type         s1_meta_ff;

   assign s1_valid_in = pipe_en ? accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_par_ff  <= par0;
         s1_pix_ff  <= rmf_pkg::pix_type'(req_tdata);
         s1_meta_ff <= meta0;
      end
   end

   // ------------------------------------------------------------------
   // Window: chain of column cells, newest column enters cell 2
   // ------------------------------------------------------------------
   rmf_pkg::col_type new_col, col_2, col_1, col_0;
   logic             shift_en;

   assign shift_en = pipe_en && s1_valid_ff;

   always_comb begin
      new_col.top = rmf_pkg::pix_type'(s1_par_ff ? bank1_rd : bank0_rd);
      new_col.mid = rmf_pkg::pix_type'(s1_par_ff ? bank0_rd : bank1_rd);
      new_col.bot = s1_pix_ff;
   end

   rmf_cell u_cell_2 (.clock(clock), .shift_en(shift_en), .col_in(new_col),
                      .col_out(col_2));
   rmf_cell u_cell_1 (.clock(clock), .shift_en(shift_en), .col_in(col_2),
                      .col_out(col_1));
   rmf_cell u_cell_0 (.clock(clock), .shift_en(shift_en), .col_in(col_1),
                      .col_out(col_0));

   // ------------------------------------------------------------------
   // Stage 2: window settled, mean computed into the output register
   // ------------------------------------------------------------------
   logic             s2_valid_ff, s2_valid_in;
   meta_type         s2_meta_ff;
   rmf_pkg::pix_type mean_pix;

   assign s2_valid_in = pipe_en ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   rmf_mean u_mean (.col_0(col_0), .col_1(col_1), .col_2(col_2), .mean(mean_pix));

   // ------------------------------------------------------------------
   // Output register with one skid entry
   // ------------------------------------------------------------------
   logic    produce, take;
   logic    out_valid_ff, out_valid_in;
   logic    out_last_ff, out_last_in;
   logic    skid_last_ff, skid_last_in;
   res_type out_ff, out_in, skid_ff, skid_in, new_res;

   assign produce = pipe_en && s2_valid_ff && s2_meta_ff.emit;
   assign take    = out_valid_ff && rsp_tready;

   always_comb begin
      new_res.pix = mean_pix;
      new_res.row = s2_meta_ff.row;
      new_res.col = s2_meta_ff.col;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      skid_full_in = skid_full_ff;
      skid_in      = skid_ff;
      skid_last_in = skid_last_ff;
      if (!out_valid_ff || take) begin
         if (skid_full_ff) begin
            out_valid_in = 1'b1;
            out_in       = skid_ff;
            out_last_in  = skid_last_ff;
            skid_full_in = 1'b0;
         end else if (produce) begin
            out_valid_in = 1'b1;
            out_in       = new_res;
            out_last_in  = s2_meta_ff.last;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (produce) begin
         skid_full_in = 1'b1;
         skid_in      = new_res;
         skid_last_in = s2_meta_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff       <= out_in;
      out_last_ff  <= out_last_in;
      skid_ff      <= skid_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff};
   assign rsp_tlast  = out_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // the skid entry only fills behind a waiting output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid entry full with empty output register");

   // raster position stays inside the configured image
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (DW'(col_ff) < width_ff) && (DW'(row_ff) < height_ff))
      else $error("raster position outside image");

   // pixels of the first row or first column are never emitted
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ff.row != '0) && (out_ff.col != '0))
      else $error("border pixel emitted");

   // the frame-last beat is the last interior column
   a_last_column: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (DW'(out_ff.col) + DW'(2)) == width_ff)
      else $error("frame last flag away from last interior column");

endmodule
